// ===== rtl/rau_pkg.sv =====
package rau_pkg;

	// Operand width of the fractions.
	localparam int OPERAND_BITS = 16;

	// Operation codes carried in the cmd field.
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_DIV = 2'd3;

	// Status codes returned with each result.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZERODEN = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;

	// Request payload.
	typedef struct packed {
		logic [1:0]                     cmd;
		logic signed [OPERAND_BITS-1:0] a_num;
		logic signed [OPERAND_BITS-1:0] a_den;
		logic signed [OPERAND_BITS-1:0] b_num;
		logic signed [OPERAND_BITS-1:0] b_den;
	} rau_in_t;

	// Result payload.
	typedef struct packed {
		logic signed [31:0] res_num;
		logic [29:0]        res_den;
		logic [1:0]         status;
	} rau_out_t;

endpackage

// ===== rtl/rau_alu.sv =====
module rau_alu import rau_pkg::*; #(
	parameter int AW = 34
) (
	input  logic [AW-1:0] opa,
	input  logic [AW-1:0] opb,
	input  logic          sub,
	output logic [AW-1:0] res,
	output logic          neg
);

	// Shared adder/subtractor; operands are always below half the range,
	// so the top bit of a difference is its sign.
	always_comb begin
		res = opa + (sub ? ~opb : opb) + AW'(sub);
		neg = res[AW-1];
	end

endmodule

// ===== rtl/rational_arith_unit.sv =====
// Sequence: multiply steps (a cross term more for add and subtract), a combine step for add
// and subtract that retries once after swapping the terms, a load step, one binary GCD step
// per cycle (shift, subtract or operand swap on the two 2 * OPERAND_BITS-bit values) and two
// restoring divisions by the GCD. A zero result numerator skips the GCD and the divisions;
// faulty operands go straight to the result. One request at a time; in_ready is high only while
// the sequencer is idle. Reset (arst_n low, asynchronous) idles the sequencer, empties the output.
module rational_arith_unit import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rau_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rau_out_t out_data
);

	localparam int OB = OPERAND_BITS;
	localparam int W  = 2 * OPERAND_BITS;
	localparam int AW = W + 2;
	localparam int CW = $clog2(W + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_COMB = 7'b0000100,
		S_LOAD = 7'b0001000,
		S_GCD  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t        state_q;
	logic [1:0]    cmd_q;
	logic [OB-1:0] an_q, ad_q, bn_q, bd_q;
	logic          nneg_q, s2_q, dneg_q;
	logic [1:0]    status_q;
	logic [W-1:0]  num_q, den_q, t2_q;
	logic [W-1:0]  gx_q, gy_q, g_q, dv_q, rem_q;
	logic [CW-1:0] cnt_q, k_q;
	logic          sel_q;
	logic          out_valid_q;
	rau_out_t      out_q;

	// Magnitudes and signs of the incoming operands.
	logic          an_n, ad_n, bn_n, bd_n;
	logic [OB-1:0] an_m, ad_m, bn_m, bd_m;
	logic          is_div;

	always_comb begin
		an_n = in_data.a_num[OB-1];
		ad_n = in_data.a_den[OB-1];
		bn_n = in_data.b_num[OB-1];
		bd_n = in_data.b_den[OB-1];
		an_m = an_n ? -in_data.a_num : in_data.a_num;
		ad_m = ad_n ? -in_data.a_den : in_data.a_den;
		bn_m = bn_n ? -in_data.b_num : in_data.b_num;
		bd_m = bd_n ? -in_data.b_den : in_data.b_den;
		is_div = (in_data.cmd == CMD_DIV);
	end

	// Shared multiplier; its operands follow the multiply step.
	logic [OB-1:0] mul_a, mul_b;
	logic [W-1:0]  prod;

	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		case (cnt_q)
			CW'(0): begin
				mul_a = an_q;
				mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
			end
			CW'(1): begin
				mul_a = ad_q;
				mul_b = (cmd_q == CMD_DIV) ? bn_q : bd_q;
			end
			default: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
		endcase
		prod = W'(mul_a) * W'(mul_b);
	end

	// Operand selection for the shared add/subtract unit.
	logic [AW-1:0] alu_a, alu_b, alu_res;
	logic          alu_sub, alu_neg;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			S_COMB: begin
				alu_a   = AW'(num_q);
				alu_b   = AW'(t2_q);
				alu_sub = (nneg_q != s2_q);
			end
			S_GCD: begin
				alu_a = AW'(gx_q);
				alu_b = AW'(gy_q);
			end
			S_DIV: begin
				alu_a = AW'({rem_q, dv_q[W-1]});
				alu_b = AW'(g_q);
			end
			S_FIN: begin
				alu_b = AW'(num_q);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	rau_alu #(.AW(AW)) u_alu (
		.opa (alu_a),
		.opb (alu_b),
		.sub (alu_sub),
		.res (alu_res),
		.neg (alu_neg)
	);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						if (in_data.a_den == '0 || in_data.b_den == '0 ||
						    (is_div && in_data.b_num == '0)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(2)) begin
						state_q <= S_COMB;
					end else if (cnt_q == CW'(1) &&
					             (cmd_q == CMD_MUL || cmd_q == CMD_DIV)) begin
						state_q <= S_LOAD;
					end
				end
				S_COMB: begin
					if (!alu_sub || !alu_neg) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					k_q <= '0;
					state_q <= (num_q == '0) ? S_FIN : S_GCD;
				end
				S_GCD: begin
					if (gx_q == gy_q) begin
						cnt_q   <= '0;
						sel_q   <= 1'b0;
						state_q <= S_DIV;
					end else if (!gx_q[0] && !gy_q[0]) begin
						k_q <= k_q + CW'(1);
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(W - 1)) begin
						cnt_q <= '0;
						sel_q <= 1'b1;
						if (sel_q) begin
							state_q <= S_FIN;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q    <= in_data.cmd;
				an_q     <= an_m;
				ad_q     <= ad_m;
				bn_q     <= bn_m;
				bd_q     <= bd_m;
				s2_q     <= (bn_n != ad_n) != (in_data.cmd == CMD_SUB);
				num_q    <= '0;
				den_q    <= W'(1);
				if (in_data.a_den == '0 || in_data.b_den == '0) begin
					status_q <= ST_ZERODEN;
					nneg_q   <= 1'b0;
					dneg_q   <= 1'b0;
				end else if (is_div && in_data.b_num == '0) begin
					status_q <= ST_DIVZERO;
					nneg_q   <= 1'b0;
					dneg_q   <= 1'b0;
				end else begin
					status_q <= ST_OK;
					nneg_q   <= (in_data.cmd == CMD_MUL) ? (an_n != bn_n) : (an_n != bd_n);
					dneg_q   <= is_div ? (ad_n != bn_n) : (ad_n != bd_n);
				end
			end
			S_MUL: begin
				case (cnt_q)
					CW'(0):  num_q <= prod;
					CW'(1):  den_q <= prod;
					default: t2_q  <= prod;
				endcase
			end
			S_COMB: begin
				if (!alu_sub || !alu_neg) begin
					num_q <= alu_res[W-1:0];
				end else begin
					// Second term is larger: swap terms and signs, then retry.
					num_q  <= t2_q;
					t2_q   <= num_q;
					nneg_q <= s2_q;
					s2_q   <= nneg_q;
				end
			end
			S_LOAD: begin
				gx_q <= num_q;
				gy_q <= den_q;
				if (num_q == '0) begin
					den_q  <= W'(1);
					nneg_q <= 1'b0;
					dneg_q <= 1'b0;
				end
			end
			S_GCD: begin
				if (gx_q == gy_q) begin
					g_q   <= gx_q << k_q;
					dv_q  <= num_q;
					rem_q <= '0;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (alu_neg) begin
					gx_q <= gy_q;
					gy_q <= gx_q;
				end else begin
					gx_q <= alu_res[W-1:0];
				end
			end
			S_DIV: begin
				// One restoring division step per cycle; the last step stores the quotient.
				if (cnt_q == CW'(W - 1)) begin
					rem_q <= '0;
					if (sel_q) begin
						den_q <= {dv_q[W-2:0], !alu_neg};
					end else begin
						num_q <= {dv_q[W-2:0], !alu_neg};
						dv_q  <= den_q;
					end
				end else begin
					rem_q <= alu_neg ? {rem_q[W-2:0], dv_q[W-1]} : alu_res[W-1:0];
					dv_q  <= {dv_q[W-2:0], !alu_neg};
				end
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end

	// Output register.
	logic [W-1:0] signed_num;

	always_comb begin
		signed_num = (nneg_q != dneg_q) ? alu_res[W-1:0] : num_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_q.res_num <= 32'(signed'(signed_num));
			out_q.res_den <= 30'(den_q);
			out_q.status  <= status_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A flagged result is always the zero fraction.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.res_num == 0 && out_q.res_den == 30'd1)
		else $error("flagged result is not 0/1");

	// The GCD operands never reach zero.
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GCD |-> gx_q != '0 && gy_q != '0)
		else $error("GCD operand became zero");

	// The division remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < g_q)
		else $error("division remainder out of range");

	// A finished result is held until the previous one has gone.
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_valid_q && !out_ready |=> state_q == S_FIN)
		else $error("result dropped while output stalled");

endmodule

// ===== dv/rational_arith_unit_tb.sv =====
`timescale 1ns / 100ps

module rational_arith_unit_tb;
	import rau_pkg::*;

	localparam int OPW        = OPERAND_BITS;
	localparam int N_RANDOM   = 1130;
	localparam int CALM_TAIL  = 150;
	localparam int STALL_LIMIT = 5000;

	typedef rau_in_t rau_req_t;

	// Holds the predicted fractions and compares them with what the block returns.
	class fraction_scoreboard;
		rau_out_t pending_q[$];
		int       mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Magnitude of a two's complement operand; the most negative value stays exact.
		function longint unsigned magnitude(logic signed [OPW-1:0] v);
			longint unsigned m;
			m = v[OPW-1] ? (longint'(1) << OPW) - longint'({1'b0, v}) :
				longint'({1'b0, v});
			return m;
		endfunction

		function longint unsigned gcd(longint unsigned x, longint unsigned y);
			longint unsigned t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		// Works out the reduced fraction for one accepted request.
		function void note_request(rau_req_t r);
			longint unsigned an, ad, bn, bd, t1, t2, nm, dm, g;
			bit              s1, s2, nneg, dneg;
			rau_out_t        e;
			an = magnitude(r.a_num);
			ad = magnitude(r.a_den);
			bn = magnitude(r.b_num);
			bd = magnitude(r.b_den);
			e.res_num = '0;
			e.res_den = 30'd1;
			if (ad == 0 || bd == 0) begin
				e.status = ST_ZERODEN;
			end else if (r.cmd == CMD_DIV && bn == 0) begin
				e.status = ST_DIVZERO;
			end else begin
				e.status = ST_OK;
				case (r.cmd) inside
					CMD_ADD, CMD_SUB: begin
						t1 = an * bd;
						s1 = r.a_num[OPW-1] ^ r.b_den[OPW-1];
						t2 = bn * ad;
						s2 = r.b_num[OPW-1] ^ r.a_den[OPW-1] ^ (r.cmd == CMD_SUB);
						if (s1 == s2) begin
							nm = t1 + t2;
							nneg = s1;
						end else if (t1 >= t2) begin
							nm = t1 - t2;
							nneg = s1;
						end else begin
							nm = t2 - t1;
							nneg = s2;
						end
						dm = ad * bd;
						dneg = r.a_den[OPW-1] ^ r.b_den[OPW-1];
					end
					CMD_MUL: begin
						nm = an * bn;
						nneg = r.a_num[OPW-1] ^ r.b_num[OPW-1];
						dm = ad * bd;
						dneg = r.a_den[OPW-1] ^ r.b_den[OPW-1];
					end
					default: begin
						nm = an * bd;
						nneg = r.a_num[OPW-1] ^ r.b_den[OPW-1];
						dm = ad * bn;
						dneg = r.a_den[OPW-1] ^ r.b_num[OPW-1];
					end
				endcase
				if (nm != 0) begin
					g = gcd(nm, dm);
					nm = nm / g;
					dm = dm / g;
					if (nneg != dneg)
						nm = -nm;
					e.res_num = nm[31:0];
					e.res_den = dm[29:0];
				end
			end
			pending_q.push_back(e);
		endfunction

		// Compares one returned fraction with the oldest prediction.
		function void check_result(rau_out_t got);
			rau_out_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result num=%0d den=%0d status=%0d",
						got.res_num, got.res_den, got.status);
				return;
			end
			e = pending_q.pop_front();
			if (got.res_num !== e.res_num || got.res_den !== e.res_den ||
				got.status !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %0d/%0d status %0d, got %0d/%0d status %0d",
						e.res_num, e.res_den, e.status,
						got.res_num, got.res_den, got.status);
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	rau_req_t in_data;
	logic     out_valid;
	logic     out_ready;
	rau_out_t out_data;

	fraction_scoreboard sb = new();
	bit idling_on = 1'b1;
	int quiet_cycles = 0;
	int stall_left = 0;

	rational_arith_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #6 clk = ~clk;

	// Result side: random back-pressure bursts, and every accepted result is checked.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_data);
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					out_ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither side moves a request or result.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("rational_arith_unit regression: fail");
			$finish;
		end
	end

	// Presents one request, with an optional gap beforehand, and waits for its handshake.
	task automatic send_request(input rau_req_t r);
		int gap;
		gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_request(r);
	endtask

	task automatic send_fields(input logic [1:0] c, input int an, input int ad,
		input int bn, input int bd);
		rau_req_t r;
		r.cmd   = c;
		r.a_num = an[OPW-1:0];
		r.a_den = ad[OPW-1:0];
		r.b_num = bn[OPW-1:0];
		r.b_den = bd[OPW-1:0];
		send_request(r);
	endtask

	// Random operand: mostly small values so that reductions are common, some zeros, extremes and full range.
	function automatic int pick_operand(bit is_den);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return is_den ? 0 : 0;
		if (sel < 8)
			return $signed($urandom_range(0, 24)) - 12;
		if (sel < 11)
			return $signed($urandom_range(0, 65535)) - 32768;
		if (sel < 13) begin
			case ($urandom_range(0, 3))
				0: return 32767;
				1: return -32767;
				2: return -32768;
				default: return ($urandom_range(0, 1) ? 1 : -1) * (1 << $urandom_range(0, 14));
			endcase
		end
		return $signed($urandom_range(0, 2000)) - 1000;
	endfunction

	initial begin
		rau_req_t r;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation, operand extremes, error precedence and zero results.
		send_fields(CMD_ADD, 1, 2, 1, 3);
		send_fields(CMD_SUB, 1, 2, 1, 3);
		send_fields(CMD_MUL, -2, 3, 9, -4);
		send_fields(CMD_DIV, 5, -7, -10, 21);
		send_fields(CMD_ADD, 32767, 32767, 32767, 32767);
		send_fields(CMD_MUL, 32767, 1, 32767, 1);
		send_fields(CMD_MUL, -32767, 1, 32767, 1);
		send_fields(CMD_DIV, 32767, 1, 1, 32767);
		send_fields(CMD_SUB, -32767, 1, 32767, 1);
		send_fields(CMD_ADD, -32767, 32766, -32767, 32765);
		send_fields(CMD_MUL, -32768, 1, -32768, 1);
		send_fields(CMD_DIV, -32768, -32768, -32768, 1);
		send_fields(CMD_ADD, 1, -32768, 1, 32767);
		send_fields(CMD_ADD, 3, 0, 1, 1);
		send_fields(CMD_MUL, 3, 1, 1, 0);
		send_fields(CMD_DIV, 3, 1, 0, 0);
		send_fields(CMD_DIV, 3, 1, 0, 5);
		send_fields(CMD_DIV, 0, 1, 0, -5);
		send_fields(CMD_SUB, 7, 3, 14, 6);
		send_fields(CMD_ADD, 7, -3, 7, 3);
		send_fields(CMD_MUL, 0, -9, 4, 5);
		send_fields(CMD_DIV, 0, 9, -4, 5);
		send_fields(CMD_ADD, -1, -1, -1, -1);

		// Random requests; the final stretch runs without idling on either side.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - CALM_TAIL)
				idling_on = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				r = $bits(rau_req_t)'({$urandom, $urandom, $urandom});
			end else begin
				r.cmd   = 2'($urandom_range(0, 3));
				r.a_num = OPW'(pick_operand(1'b0));
				r.a_den = OPW'(pick_operand(1'b1));
				r.b_num = OPW'(pick_operand(1'b0));
				r.b_den = OPW'(pick_operand(1'b1));
			end
			send_request(r);
		end
		in_valid <= 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("rational_arith_unit regression: pass");
		else
			$display("rational_arith_unit regression: fail");
		$finish;
	end

endmodule
